// ===== rtl/two_lane_keyed_queue_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-lane keyed queue
// Immediate-implication and next-cycle-implication checks, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef TWO_LANE_KEYED_QUEUE_UNIT_MACROS_SVH
`define TWO_LANE_KEYED_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define TLKQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define TLKQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TLKQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg)
`define TLKQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/tlkq_pkg.sv =====
// ----------------------------------------------------------------------------
// tlkq_pkg
// Shared widths, codes and helpers for the two-lane keyed queue.
// ----------------------------------------------------------------------------
package tlkq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_MAX_POINTS  = 15;

    localparam int ID_W      = 16;
    localparam int ENTRY_W   = ID_W + 1;     // live bit above the id
    localparam int REV_W     = 63;
    localparam int CFG_W     = 4;
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_RESOLVE = 2'd2;
    localparam logic [1:0] CMD_KILL    = 2'd3;

    localparam logic [1:0] LANE_NONE = 2'd0;
    localparam logic [1:0] LANE_ONE  = 2'd1;
    localparam logic [1:0] LANE_TWO  = 2'd2;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_SERVICE  = 2'd1;
    localparam logic [1:0] KIND_POINT    = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    // register select, taken from paddr[2]
    localparam logic REG_LANE1_POINTS = 1'b0;
    localparam logic REG_LANE2_POINTS = 1'b1;

    // advance a revision, wrapping from the maximum to one
    function automatic logic [REV_W-1:0] rev_advance(input logic [REV_W-1:0] r);
        rev_advance = (r == {REV_W{1'b1}}) ? REV_W'(1) : r + REV_W'(1);
    endfunction

endpackage

// ===== rtl/two_lane_keyed_queue_unit.sv =====
// ----------------------------------------------------------------------------
// two_lane_keyed_queue_unit: two ordered client queues with compaction
// Enqueue and kill scan both lanes, lane one first; dequeue and resolve scan
// only the addressed lane, and a request that needs no scan skips the scan
// state. Scan time comes from one RAM read port scanning one entry a cycle.
// One request is in work at a time; the next is taken the cycle after the
// result is issued. A finished request waits while the output register holds
// an unaccepted result.
// Reset clears lengths, revisions and point counts; entries are not cleared.
// ----------------------------------------------------------------------------
`include "two_lane_keyed_queue_unit_macros.svh"

module two_lane_keyed_queue_unit #(
    parameter int QUEUE_DEPTH = tlkq_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_POINTS  = tlkq_pkg::DEF_MAX_POINTS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tlkq_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] client_id
    input  logic [tlkq_pkg::S_TUSER_W-1:0] s_tuser,   // [1:0] command, [3:2] lane
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] ok, [1] full_res, [5:2] position, [9:6] point_index,
    // [72:10] revision, [79:73] zero
    output logic [tlkq_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [tlkq_pkg::M_TUSER_W-1:0] m_tuser,   // [1:0] kind
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tlkq_pkg::PADDR_W-1:0]   paddr,
    input  logic [tlkq_pkg::PDATA_W-1:0]   pwdata,
    output logic [tlkq_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    localparam int IW   = $clog2(QUEUE_DEPTH);
    localparam int AW   = IW + 1;
    localparam int LW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (LW > 8) ? LW : 8;
    localparam int IDW  = tlkq_pkg::ID_W;
    localparam int EW   = tlkq_pkg::ENTRY_W;
    localparam int RW   = tlkq_pkg::REV_W;
    localparam int CW   = tlkq_pkg::CFG_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_REPLY  = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [LW-1:0]               len_reg [2];
    logic [LW-1:0]               len_next [2];
    logic [RW-1:0]               rev1_reg, rev1_next;
    logic [RW-1:0]               rev2_reg, rev2_next;
    logic [CW-1:0]               pc1_reg, pc2_reg;
    logic                        m_tvalid_reg, m_tvalid_next;

    logic [1:0]                  cmd_reg, cmd_next;
    logic [1:0]                  lane_reg, lane_next;
    logic [IDW-1:0]              id_reg, id_next;
    logic                        lane_sel_reg, lane_sel_next;
    logic [LW-1:0]               idx_reg, idx_next;
    logic [LW-1:0]               w_reg, w_next;
    logic [LW-1:0]               pidx_reg, pidx_next;
    logic                        pv_reg, pv_next;
    logic [1:0]                  found_reg, found_next;
    logic [1:0]                  chg_reg, chg_next;
    logic [LW-1:0]               ahead_reg, ahead_next;
    logic                        res_ok_reg, res_ok_next;
    logic                        res_full_reg, res_full_next;
    logic [1:0]                  res_kind_reg, res_kind_next;
    logic [3:0]                  res_pos_reg, res_pos_next;
    logic [3:0]                  res_pidx_reg, res_pidx_next;
    logic [tlkq_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [tlkq_pkg::M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [EW-1:0]               ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [EW-1:0]               ram_rdata;

    logic                        rd_live;
    logic [IDW-1:0]              rd_id;
    logic                        rd_hit;
    logic                        scan_issue;
    logic                        lane_two;
    logic                        lane_ok;
    logic                        cfg_wr;
    logic [CMPW-1:0]             ahead_x;
    logic [CMPW-1:0]             ahead_m1;
    logic [CMPW-1:0]             pc_raw;
    logic [CMPW-1:0]             pc_eff;
    logic [RW-1:0]               rev_sel;

    tlkq_ram #(
        .WIDTH (EW),
        .DEPTH (2 ** AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == tlkq_pkg::REG_LANE2_POINTS) ?
                    {{(tlkq_pkg::PDATA_W-CW){1'b0}}, pc2_reg} :
                    {{(tlkq_pkg::PDATA_W-CW){1'b0}}, pc1_reg};

    // scan compare unit
    assign rd_live    = ram_rdata[IDW];
    assign rd_id      = ram_rdata[IDW-1:0];
    assign rd_hit     = rd_live && (rd_id == id_reg) && (id_reg != '0);
    assign scan_issue = (idx_reg < len_reg[lane_sel_reg]);

    assign lane_two = (lane_reg == tlkq_pkg::LANE_TWO);
    assign lane_ok  = (lane_reg == tlkq_pkg::LANE_ONE) || lane_two;

    // resolve mapping
    assign ahead_x  = CMPW'(ahead_reg);
    assign ahead_m1 = ahead_x - CMPW'(1);
    assign pc_raw   = lane_two ? CMPW'(pc2_reg) : CMPW'(pc1_reg);
    assign pc_eff   = (pc_raw > CMPW'(MAX_POINTS)) ? CMPW'(MAX_POINTS) : pc_raw;

    assign rev_sel = (lane_reg == tlkq_pkg::LANE_ONE) ? rev1_reg :
                     (lane_reg == tlkq_pkg::LANE_TWO) ? rev2_reg : '0;

    always_comb begin : p_next
        logic [1:0] chg_eff;
        logic       in_two;
        logic       in_ok;
        logic [1:0] in_cmd;
        logic [1:0] in_lane;

        state_next    = state_reg;
        len_next[0]   = len_reg[0];
        len_next[1]   = len_reg[1];
        rev1_next     = rev1_reg;
        rev2_next     = rev2_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd_next      = cmd_reg;
        lane_next     = lane_reg;
        id_next       = id_reg;
        lane_sel_next = lane_sel_reg;
        idx_next      = idx_reg;
        w_next        = w_reg;
        pidx_next     = pidx_reg;
        pv_next       = pv_reg;
        found_next    = found_reg;
        chg_next      = chg_reg;
        ahead_next    = ahead_reg;
        res_ok_next   = res_ok_reg;
        res_full_next = res_full_reg;
        res_kind_next = res_kind_reg;
        res_pos_next  = res_pos_reg;
        res_pidx_next = res_pidx_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = {lane_sel_reg, idx_reg[IW-1:0]};
        chg_eff       = chg_reg;
        in_cmd        = s_tuser[1:0];
        in_lane       = s_tuser[3:2];
        in_two        = (in_lane == tlkq_pkg::LANE_TWO);
        in_ok         = (in_lane == tlkq_pkg::LANE_ONE) || in_two;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = in_cmd;
                    lane_next  = in_lane;
                    id_next    = s_tdata[IDW-1:0];
                    idx_next   = '0;
                    w_next     = '0;
                    pv_next    = 1'b0;
                    found_next = '0;
                    chg_next   = '0;
                    ahead_next = '0;
                    // enqueue and kill sweep lane one first, then lane two
                    lane_sel_next = ((in_cmd == tlkq_pkg::CMD_ENQUEUE) ||
                                     (in_cmd == tlkq_pkg::CMD_KILL)) ? 1'b0 : in_two;
                    if ((in_cmd == tlkq_pkg::CMD_ENQUEUE) ||
                        (in_cmd == tlkq_pkg::CMD_KILL) ||
                        ((in_cmd == tlkq_pkg::CMD_DEQUEUE) && in_ok) ||
                        ((in_cmd == tlkq_pkg::CMD_RESOLVE) && in_ok &&
                         (s_tdata[IDW-1:0] != '0))) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_SCAN: begin
                if (scan_issue) begin
                    idx_next = idx_reg + LW'(1);
                end
                pv_next   = scan_issue;
                pidx_next = idx_reg;

                if (pv_reg) begin
                    unique case (cmd_reg)
                        tlkq_pkg::CMD_ENQUEUE, tlkq_pkg::CMD_DEQUEUE: begin
                            if (rd_hit) begin
                                found_next[lane_sel_reg] = 1'b1;
                            end
                            if (!rd_live) begin
                                chg_next[lane_sel_reg] = 1'b1;
                            end
                            // keep live entries; dequeue also drops matches
                            if (rd_live && !((cmd_reg == tlkq_pkg::CMD_DEQUEUE) && rd_hit)) begin
                                ram_we    = 1'b1;
                                ram_waddr = {lane_sel_reg, w_reg[IW-1:0]};
                                ram_wdata = ram_rdata;
                                w_next    = w_reg + LW'(1);
                            end
                        end
                        tlkq_pkg::CMD_RESOLVE: begin
                            if (!found_reg[lane_sel_reg]) begin
                                if (rd_hit) begin
                                    found_next[lane_sel_reg] = 1'b1;
                                end else if (rd_live) begin
                                    ahead_next = ahead_reg + LW'(1);
                                end
                            end
                        end
                        tlkq_pkg::CMD_KILL: begin
                            if (rd_hit) begin
                                found_next[lane_sel_reg] = 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = {lane_sel_reg, pidx_reg[IW-1:0]};
                                ram_wdata = {1'b0, rd_id};
                            end
                        end
                        default: ;
                    endcase
                end

                if (!pv_reg && !scan_issue) begin
                    if ((cmd_reg == tlkq_pkg::CMD_ENQUEUE) ||
                        (cmd_reg == tlkq_pkg::CMD_DEQUEUE)) begin
                        len_next[lane_sel_reg] = w_reg;
                    end
                    if (((cmd_reg == tlkq_pkg::CMD_ENQUEUE) ||
                         (cmd_reg == tlkq_pkg::CMD_KILL)) && !lane_sel_reg) begin
                        lane_sel_next = 1'b1;
                        idx_next      = '0;
                        w_next        = '0;
                    end else begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE: begin
                res_ok_next   = 1'b0;
                res_full_next = 1'b0;
                res_kind_next = tlkq_pkg::KIND_NONE;
                res_pos_next  = '0;
                res_pidx_next = '0;
                unique case (cmd_reg)
                    tlkq_pkg::CMD_ENQUEUE: begin
                        if ((id_reg != '0) && lane_ok) begin
                            if (|found_reg) begin
                                res_ok_next = found_reg[lane_two];
                            end else if (len_reg[lane_two] >= LW'(QUEUE_DEPTH)) begin
                                res_full_next = 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = {lane_two, len_reg[lane_two][IW-1:0]};
                                ram_wdata = {1'b1, id_reg};
                                len_next[lane_two] = len_reg[lane_two] + LW'(1);
                                chg_eff[lane_two]  = 1'b1;
                                res_ok_next        = 1'b1;
                            end
                        end
                        if (chg_eff[0]) begin
                            rev1_next = tlkq_pkg::rev_advance(rev1_reg);
                        end
                        if (chg_eff[1]) begin
                            rev2_next = tlkq_pkg::rev_advance(rev2_reg);
                        end
                    end
                    tlkq_pkg::CMD_DEQUEUE: begin
                        if (lane_ok) begin
                            if (chg_reg[lane_two] || found_reg[lane_two]) begin
                                if (lane_two) begin
                                    rev2_next = tlkq_pkg::rev_advance(rev2_reg);
                                end else begin
                                    rev1_next = tlkq_pkg::rev_advance(rev1_reg);
                                end
                            end
                            res_ok_next = found_reg[lane_two];
                        end
                    end
                    tlkq_pkg::CMD_RESOLVE: begin
                        if (found_reg[lane_two]) begin
                            if (ahead_reg == '0) begin
                                res_ok_next   = 1'b1;
                                res_kind_next = tlkq_pkg::KIND_SERVICE;
                            end else if (ahead_m1 < pc_eff) begin
                                res_ok_next   = 1'b1;
                                res_kind_next = tlkq_pkg::KIND_POINT;
                                res_pidx_next = (ahead_m1 > CMPW'(15)) ? 4'd15 : ahead_m1[3:0];
                            end else if (lane_two) begin
                                res_ok_next   = 1'b1;
                                res_kind_next = tlkq_pkg::KIND_OVERFLOW;
                            end
                            if ((ahead_reg == '0) || (ahead_m1 < pc_eff) || lane_two) begin
                                res_pos_next = (ahead_x > CMPW'(15)) ? 4'd15 : ahead_x[3:0];
                            end
                        end
                    end
                    tlkq_pkg::CMD_KILL: begin
                        res_ok_next = |found_reg;
                    end
                    default: ;
                endcase
                state_next = ST_REPLY;
            end

            ST_REPLY: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next       = 1'b1;
                    m_tdata_next        = '0;
                    m_tdata_next[0]     = res_ok_reg;
                    m_tdata_next[1]     = res_full_reg;
                    m_tdata_next[5:2]   = res_pos_reg;
                    m_tdata_next[9:6]   = res_pidx_reg;
                    m_tdata_next[72:10] = rev_sel;
                    m_tuser_next        = res_kind_reg;
                    state_next          = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_reg[0]   <= '0;
            len_reg[1]   <= '0;
            rev1_reg     <= '0;
            rev2_reg     <= '0;
            pc1_reg      <= '0;
            pc2_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg[0]   <= len_next[0];
            len_reg[1]   <= len_next[1];
            rev1_reg     <= rev1_next;
            rev2_reg     <= rev2_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr) begin
                if (paddr[2] == tlkq_pkg::REG_LANE2_POINTS) begin
                    pc2_reg <= pwdata[CW-1:0];
                end else begin
                    pc1_reg <= pwdata[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        lane_reg     <= lane_next;
        id_reg       <= id_next;
        lane_sel_reg <= lane_sel_next;
        idx_reg      <= idx_next;
        w_reg        <= w_next;
        pidx_reg     <= pidx_next;
        pv_reg       <= pv_next;
        found_reg    <= found_next;
        chg_reg      <= chg_next;
        ahead_reg    <= ahead_next;
        res_ok_reg   <= res_ok_next;
        res_full_reg <= res_full_next;
        res_kind_reg <= res_kind_next;
        res_pos_reg  <= res_pos_next;
        res_pidx_reg <= res_pidx_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    `TLKQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "block still ready after taking a request")
    `TLKQ_ASSERT_NOW(a_resolve_no_write, aclk, aresetn, (state_reg == ST_SCAN) && (cmd_reg == tlkq_pkg::CMD_RESOLVE), !ram_we, "resolve scan wrote the entry store")
    `TLKQ_ASSERT_NOW(a_compact_behind_read, aclk, aresetn, (state_reg == ST_SCAN) && pv_reg, w_reg <= pidx_reg, "compaction write ran ahead of the read pointer")
    `TLKQ_ASSERT_NOW(a_len1_range, aclk, aresetn, 1'b1, len_reg[0] <= LW'(QUEUE_DEPTH), "lane one length beyond depth")
    `TLKQ_ASSERT_NOW(a_len2_range, aclk, aresetn, 1'b1, len_reg[1] <= LW'(QUEUE_DEPTH), "lane two length beyond depth")

endmodule

// ===== rtl/tlkq_ram.sv =====
// ----------------------------------------------------------------------------
// tlkq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tlkq_ram #(
    parameter int WIDTH = tlkq_pkg::ENTRY_W,
    parameter int DEPTH = 2 * tlkq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
